// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BLVE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// property checked on every rising edge, also during reset
`define BLVE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/blve_pkg.sv =====
// ----------------------------------------------------------------------------
// blve_pkg
// Shared types, codes and sizes of the bounded value list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blve_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_WIDTH = 2;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 5;

    // request tdata: opcode, value
    localparam int IN_OPCODE_LSB = 0;
    localparam int IN_VALUE_LSB  = IN_OPCODE_LSB + OPCODE_WIDTH;
    localparam int IN_BITS       = IN_VALUE_LSB + VALUE_WIDTH;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    // result tdata: status, found, entry_count, max_value, max_valid
    localparam int OUT_FOUND_LSB = STATUS_WIDTH;
    localparam int OUT_COUNT_LSB = OUT_FOUND_LSB + 1;
    localparam int OUT_MAX_LSB   = OUT_COUNT_LSB + COUNT_WIDTH;
    localparam int OUT_MVAL_LSB  = OUT_MAX_LSB + VALUE_WIDTH;
    localparam int OUT_BITS      = OUT_MVAL_LSB + 1;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_BITS;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

endpackage

// ===== rtl/blve_cell.sv =====
// ----------------------------------------------------------------------------
// blve_cell
// One list entry of the ring; takes its input word (its neighbor's, or the tail word for the last cell) on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blve_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic [DATA_WIDTH-1:0] d,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

// ===== rtl/blve_seq.sv =====
// ----------------------------------------------------------------------------
// blve_seq
// Request sequencer: rotates the cell ring once per request, rebuilds the
// list at the tail cell and collects count, match and maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blve_seq import blve_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode, value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status, found, entry_count, max_value, max_valid
    input  logic [DATA_WIDTH-1:0]  head,
    input  logic [DATA_WIDTH-1:0]  next,
    output logic                   shift,
    output logic [DATA_WIDTH-1:0]  tail
);

    localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH
    } state_t;

    typedef enum logic [1:0] {
        MODE_INSERT,
        MODE_DELETE,
        MODE_PASS
    } mode_t;

    state_t                  state_reg;
    mode_t                   mode_reg;
    opcode_t                 op_reg;
    status_t                 base_reg;
    logic [KW-1:0]           k_reg;
    logic [CW-1:0]           count_reg;
    logic [DATA_WIDTH-1:0]   v_reg;
    logic [DATA_WIDTH-1:0]   carry_reg;
    logic                    placed_reg;
    logic                    found_reg;
    logic [DATA_WIDTH-1:0]   max_reg;
    logic                    max_valid_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    opcode_t                 in_op;
    logic [DATA_WIDTH-1:0]   in_value;
    logic [CW-1:0]           k_ext;
    logic                    in_use;
    logic                    at_tail;
    logic                    match;
    logic                    found_next;
    logic [DATA_WIDTH-1:0]   out_word;
    logic [DATA_WIDTH-1:0]   carry_next;
    logic                    placed_next;
    logic                    keep_word;
    logic                    out_free;
    logic                    last_step;
    status_t                 status_out;
    logic [VALUE_WIDTH-1:0]  max_out;

    assign in_op    = opcode_t'(s_tdata[IN_OPCODE_LSB +: OPCODE_WIDTH]);
    assign in_value = DATA_WIDTH'(s_tdata[IN_VALUE_LSB +: VALUE_WIDTH]);

    assign k_ext     = CW'(k_reg);
    assign in_use    = (k_ext < count_reg);
    assign at_tail   = (k_ext == count_reg);
    assign match     = in_use && (head == v_reg) && !found_reg;
    assign last_step = (k_reg == KW'(CAPACITY - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        out_word    = head;
        carry_next  = carry_reg;
        placed_next = placed_reg;
        found_next  = found_reg;
        keep_word   = in_use;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                keep_word = (k_ext <= count_reg);
                if (in_use)
                begin
                    if (placed_reg)
                    begin
                        out_word   = carry_reg;
                        carry_next = head;
                    end
                    else if ((op_reg == OP_INSERT) && ($signed(head) >= $signed(v_reg)))
                    begin
                        out_word    = v_reg;
                        carry_next  = head;
                        placed_next = 1'b1;
                    end
                end
                else if (at_tail)
                begin
                    out_word = placed_reg ? carry_reg : v_reg;
                end
            end
            MODE_DELETE:
            begin
                found_next = found_reg || match;
                if (found_next)
                begin
                    out_word = next;
                end
                keep_word = ((k_ext + CW'(1)) < count_reg) ||
                            (((k_ext + CW'(1)) == count_reg) && !found_next);
            end
            default:
            begin
                if (op_reg == OP_SEARCH)
                begin
                    found_next = found_reg || match;
                end
            end
        endcase
    end

    assign status_out = (((op_reg == OP_SEARCH) || (mode_reg == MODE_DELETE)) && found_reg)
                        ? STAT_OK : base_reg;
    assign max_out    = max_valid_reg ? VALUE_WIDTH'($signed(max_reg)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_PASS;
            op_reg        <= OP_APPEND;
            base_reg      <= STAT_OK;
            k_reg         <= '0;
            count_reg     <= '0;
            v_reg         <= '0;
            carry_reg     <= '0;
            placed_reg    <= 1'b0;
            found_reg     <= 1'b0;
            max_reg       <= '0;
            max_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            if (m_tready && (state_reg != S_PUSH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg        <= in_op;
                        v_reg         <= in_value;
                        k_reg         <= '0;
                        placed_reg    <= 1'b0;
                        found_reg     <= 1'b0;
                        max_valid_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                        if ((in_op == OP_APPEND) || (in_op == OP_INSERT))
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                mode_reg <= MODE_PASS;
                                base_reg <= STAT_FULL;
                            end
                            else
                            begin
                                mode_reg <= MODE_INSERT;
                                base_reg <= STAT_OK;
                            end
                        end
                        else if ((in_op == OP_DELETE) && (count_reg != '0))
                        begin
                            mode_reg <= MODE_DELETE;
                            base_reg <= STAT_NOT_FOUND;
                        end
                        else if (in_op == OP_DELETE)
                        begin
                            mode_reg <= MODE_PASS;
                            base_reg <= STAT_EMPTY;
                        end
                        else
                        begin
                            mode_reg <= MODE_PASS;
                            base_reg <= STAT_NOT_FOUND;
                        end
                    end
                end
                S_SCAN:
                begin
                    carry_reg  <= carry_next;
                    placed_reg <= placed_next;
                    found_reg  <= found_next;
                    k_reg      <= k_reg + KW'(1);
                    if (keep_word && (!max_valid_reg || ($signed(out_word) > $signed(max_reg))))
                    begin
                        max_reg       <= out_word;
                        max_valid_reg <= 1'b1;
                    end
                    if (last_step)
                    begin
                        state_reg <= S_PUSH;
                        if (mode_reg == MODE_INSERT)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else if ((mode_reg == MODE_DELETE) && found_next)
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                end
                S_PUSH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{OUT_PAD_W{1'b0}}, max_valid_reg, max_out,
                                         COUNT_WIDTH'(count_reg), found_reg, status_out};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign shift    = (state_reg == S_SCAN);
    assign tail     = out_word;

endmodule

// ===== rtl/bounded_value_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_value_list_engine_unit
// Ordered list of signed values with append, sorted insert, delete and search.
// ----------------------------------------------------------------------------
// A request is taken while the engine is idle and then turns the ring of cells
// once, one entry passing the head cell per cycle, while the list is rebuilt
// at the tail and the count, match and maximum are gathered. The result is then
// registered in the output register, and the next request can be accepted from
// that same cycle on, so the engine takes no new request while one is in flight.
// A result that has not been taken when the next one is ready holds the engine
// until it is taken. There is no clearing pass after reset.
`timescale 1ns / 1ps

module bounded_value_list_engine_unit import blve_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode, value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, found, entry_count, max_value, max_valid
);

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic                  shift;
    logic [DATA_WIDTH-1:0] tail;

    blve_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .head     (cell_q[0]),
        .next     (cell_q[1]),
        .shift    (shift),
        .tail     (tail)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_last
            blve_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (tail),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_mid
            blve_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

endmodule

// ===== rtl/blve_checker.sv =====
// ----------------------------------------------------------------------------
// blve_checker
// Port-level checks of the bounded value list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blve_checker import blve_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode, value
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, found, entry_count, max_value, max_valid
);

    logic                   req_take;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   res_mval;
    logic [VALUE_WIDTH-1:0] res_max;

    assign req_take  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
    assign res_count = m_axis_tdata[OUT_COUNT_LSB +: COUNT_WIDTH];
    assign res_mval  = m_axis_tdata[OUT_MVAL_LSB];
    assign res_max   = m_axis_tdata[OUT_MAX_LSB +: VALUE_WIDTH];

    // one request at a time: the engine is busy right after taking one
    `BLVE_ASSERT(a_busy_after_take, clk, rst_n, req_take |=> !s_axis_tready)

    // a held result stays put
    `BLVE_ASSERT(a_result_held, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // maximum is flagged exactly when the list holds entries, and reads zero otherwise
    `BLVE_ASSERT(a_max_flag, clk, rst_n, m_axis_tvalid |-> (CAPACITY > 31) || ((res_mval == (res_count != '0)) && (res_mval || (res_max == '0))))

    // entry count never exceeds the capacity
    `BLVE_ASSERT(a_count_bound, clk, rst_n, m_axis_tvalid |-> (CAPACITY > 31) || (res_count <= COUNT_WIDTH'(CAPACITY)))

    // no result can appear in the cycle right after reset release
    `BLVE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind bounded_value_list_engine_unit blve_checker #(
    .CAPACITY (CAPACITY)
) u_blve_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
